FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
// Each macro expects i_clk and i_rst_n in scope (synchronous, active-low reset).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/mcrtb_pkg.sv
// ----------------------------------------------------------------------------
// mcrtb_pkg
// Types and codes shared by the timer bank: commands, sequencer states and
// the layout of one timer entry in the state memory.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrtb_pkg;

    localparam int CNT_W = 32;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_INIT   = 2'd1,
        CMD_CHANGE = 2'd2,
        CMD_CHECK  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_RMW
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] remaining;
        logic [CNT_W-1:0] reload;
        logic             auto_rl;
        logic             flag;
    } t_entry;

endpackage

`default_nettype wire

FILE: hw/rtl/mcrtb_ram.sv
// ----------------------------------------------------------------------------
// mcrtb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/multi_channel_reload_timer_bank.sv
// ----------------------------------------------------------------------------
// multi_channel_reload_timer_bank
// Bank of down-counting timers with one-shot or auto-reload mode, driven by
// tick / init / change / check command words.
// ----------------------------------------------------------------------------
// All timer state (count, reload value, mode, expired flag) lives in one entry
// per timer in a single RAM with registered read. A tick word sweeps every
// entry, one per cycle, reading the next entry while writing back the
// current one; that sweep through the single RAM read port sets the tick
// rate. Init, change and check words read the entry, then modify and write
// it back. Check returns one result word holding the old flag and clears it;
// an index at or above NUM_TIMERS is ignored, and a check on it returns 0.
// The input side is stalled while a word is in progress. A pending result
// sits in an output register, so ticks, inits and changes keep flowing while
// it waits; only a further check waits for it to drain. Reset clears a
// per-entry valid bit array instead of the RAM, so there is no clearing
// pass: an entry never written reads as all zero, and the block accepts
// words right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multi_channel_reload_timer_bank
    import mcrtb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command words
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_timer_index,
    input  wire logic        i_reload_mode,
    input  wire logic [31:0] i_period,
    // result words
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_expired
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int EW = $bits(t_entry);

    // sequencer
    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic            r_ok, n_ok;          // index in range
    logic [AW-1:0]   r_addr, n_addr;      // entry whose read data is in the RAM output

    // captured payload
    logic            r_mode;
    logic [CNT_W-1:0] r_period;

    // entry valid bits: cleared at reset, set on first write
    logic [NUM_TIMERS-1:0] r_valid;
    logic            r_live;              // read data came from a written entry

    // result register
    logic            r_out_vld, n_out_vld;
    logic            r_expired, n_expired;

    // RAM ports
    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr;
    logic [EW-1:0]   rd_data;
    t_entry          wr_data;
    t_entry          cur;

    logic            in_acc;
    logic            in_ok;
    logic            rd_ok;

    assign in_acc = i_in_valid && !o_in_stall;
    assign in_ok  = ({1'b0, i_timer_index} < 9'(NUM_TIMERS));
    // never-written entries read as the reset value
    assign cur    = r_live ? t_entry'(rd_data) : '0;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_expired   = r_expired;

    mcrtb_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // next state and datapath
    always_comb begin
        t_entry nxt;
        nxt       = cur;
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ok      = r_ok;
        n_addr    = r_addr;
        rd_en     = 1'b0;
        rd_addr   = r_addr;
        rd_ok     = 1'b1;
        wr_en     = 1'b0;
        n_out_vld = r_out_vld && i_out_stall;
        n_expired = r_expired;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = t_cmd'(i_command);
                    n_ok  = in_ok;
                    if (t_cmd'(i_command) == CMD_TICK) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_addr  = '0;
                        n_state = ST_TICK;
                    end else begin
                        rd_en   = in_ok;
                        rd_ok   = in_ok;
                        rd_addr = i_timer_index[AW-1:0];
                        n_addr  = i_timer_index[AW-1:0];
                        n_state = ST_RMW;
                    end
                end
            end

            ST_TICK: begin
                // decrement the entry just read, fetch the next one
                if (cur.remaining != '0) begin
                    nxt.remaining = cur.remaining - 1'b1;
                    if (nxt.remaining == '0) begin
                        nxt.flag = 1'b1;
                        if (cur.auto_rl) begin
                            nxt.remaining = cur.reload;
                        end
                    end
                end
                wr_en = 1'b1;
                if (r_addr == AW'(NUM_TIMERS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                    n_addr  = rd_addr;
                end
            end

            ST_RMW: begin
                // a check waits here until the result register is free
                if (!(r_cmd == CMD_CHECK && r_out_vld && i_out_stall)) begin
                    n_state = ST_IDLE;
                    wr_en   = r_ok;
                    case (r_cmd)
                        CMD_INIT: begin
                            nxt.remaining = r_period;
                            nxt.reload    = r_period;
                            nxt.auto_rl   = r_mode;
                        end
                        CMD_CHANGE: begin
                            nxt.reload  = r_period;
                            nxt.auto_rl = r_mode;
                        end
                        CMD_CHECK: begin
                            nxt.flag  = 1'b0;
                            n_out_vld = 1'b1;
                            n_expired = r_ok && cur.flag;
                        end
                        default: begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        wr_data = nxt;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmd     <= CMD_TICK;
            r_ok      <= 1'b0;
            r_addr    <= '0;
            r_valid   <= '0;
            r_live    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmd     <= n_cmd;
            r_ok      <= n_ok;
            r_addr    <= n_addr;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_live <= rd_ok && r_valid[rd_addr];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= i_reload_mode;
            r_period <= i_period;
        end
        r_expired <= n_expired;
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `ASSERT_NEVER(a_no_wr_idle, (r_state == ST_IDLE) && wr_en, "RAM write while idle")
    `ASSERT_NEVER(a_no_rw_clash, rd_en && wr_en && (rd_addr == r_addr),
        "read and write of the same entry in one cycle")
    `ASSERT_IMPL(a_sweep_order, (r_state == ST_TICK), (r_addr == $past(rd_addr)),
        "tick write-back address does not follow the read address")
    `ASSERT_IMPL(a_result_src, $rose(r_out_vld), ($past(r_state) == ST_RMW),
        "result loaded outside a check")

endmodule

`default_nettype wire

FILE: verif/tb_multi_channel_reload_timer_bank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_channel_reload_timer_bank
// Self-checking bench for the timer bank. Command words go in through a
// bursty valid/stall sender. A local copy of the bank's state predicts the
// expired bit that each check returns. The result side stalls on its own
// random runs, with one long hold-off that backs the block up. The run has
// directed cases first (idle timers, one-shot, auto-reload, zero reload,
// out-of-range indexes, init keeping the flag, back-pressure) and then
// random phases with different idling settings.
// ----------------------------------------------------------------------------
module tb_multi_channel_reload_timer_bank;
    import mcrtb_pkg::*;

    localparam int NUM_TIMERS     = 16;
    // a tick sweeps every entry once, plus the read/write-back overlap
    localparam int SWEEP_CYCLES   = NUM_TIMERS + 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF       = 300;
    localparam int MAX_REPORTS    = 10;

    // ------------------------------------------------------------------------
    // DUT ports; the inputs are known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_command     = CMD_TICK;
    logic [7:0]  i_timer_index = '0;
    logic        i_reload_mode = 1'b0;
    logic [31:0] i_period      = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_expired;

    multi_channel_reload_timer_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_timer_index (i_timer_index),
        .i_reload_mode (i_reload_mode),
        .i_period      (i_period),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_expired     (o_expired)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted bank state: one count, reload, mode and flag per timer
    // ------------------------------------------------------------------------
    bit [31:0] tmr_left   [NUM_TIMERS];
    bit [31:0] tmr_reload [NUM_TIMERS];
    bit        tmr_auto   [NUM_TIMERS];
    bit        tmr_flag   [NUM_TIMERS];

    // expired bits still owed by the block, oldest first
    bit expected_flags[$];

    // sender shaping: bursts of up to burst_max words, gaps of up to gap_max
    int burst_max  = 4;
    int gap_max    = 2;
    int burst_left = 0;

    // receiver shaping: stall_pct percent stalled, in runs; hold_req asks for
    // a long hold-off that the stall process counts down itself
    int stall_pct = 25;
    int hold_req  = 0;
    int hold_left = 0;
    int stall_run = 0;

    // bookkeeping
    int n_words [4];
    int n_results    = 0;
    int n_flags_seen = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    // Apply one accepted word to the predicted state. Every nonzero count
    // steps down on a tick; reaching zero sets the flag and, in auto-reload,
    // loads the reload value (zero reload leaves the timer idle). Indexes at
    // or above NUM_TIMERS are dropped, and a check on one owes a 0.
    task automatic bank_model_step(t_cmd cmd, bit [7:0] idx, bit mode, bit [31:0] per);
        bit in_range;
        in_range = (idx < NUM_TIMERS);
        case (cmd)
            CMD_TICK: begin
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    if (tmr_left[k] != 0) begin
                        tmr_left[k]--;
                        if (tmr_left[k] == 0) begin
                            tmr_flag[k] = 1'b1;
                            if (tmr_auto[k])
                                tmr_left[k] = tmr_reload[k];
                        end
                    end
                end
            end
            CMD_INIT: begin
                // init leaves the flag alone
                if (in_range) begin
                    tmr_left[idx]   = per;
                    tmr_reload[idx] = per;
                    tmr_auto[idx]   = mode;
                end
            end
            CMD_CHANGE: begin
                if (in_range) begin
                    tmr_reload[idx] = per;
                    tmr_auto[idx]   = mode;
                end
            end
            CMD_CHECK: begin
                if (in_range && tmr_flag[idx]) begin
                    tmr_flag[idx] = 1'b0;
                    expected_flags.push_back(1'b1);
                    n_flags_seen++;
                end else begin
                    expected_flags.push_back(1'b0);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one word, wait for the handshake, then predict.
    // Called right after a rising edge; valid stays high between back-to-back
    // words and is only dropped for a gap.
    // ------------------------------------------------------------------------
    task automatic offer_word(t_cmd cmd, bit [7:0] idx, bit mode, bit [31:0] per);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_timer_index <= idx;
        i_reload_mode <= mode;
        i_period      <= per;
        do @(posedge i_clk); while (o_in_stall);
        bank_model_step(cmd, idx, mode, per);
        n_words[cmd]++;
    endtask

    // Sender pauses until every owed result has come back, then lets a
    // tick sweep's worth of cycles go by.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_flags.size() != 0) @(posedge i_clk);
        repeat (SWEEP_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            stall_run = 0;
            i_out_stall <= 1'b1;
        end else if (stall_run != 0) begin
            stall_run--;
        end else begin
            stall_run = $urandom_range(0, 3);
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result word against the oldest owed bit
    // ------------------------------------------------------------------------
    task automatic note_mismatch(string what, bit want, logic got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected expired=%0b, got %0b", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_flags.size() == 0) begin
                note_mismatch("result word with nothing owed", 1'b0, o_expired);
            end else begin
                want = expected_flags.pop_front();
                if (o_expired !== want)
                    note_mismatch("wrong expired bit", want, o_expired);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any word moving on either side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL multi_channel_reload_timer_bank");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Directed cases
    // ------------------------------------------------------------------------

    // nothing set after reset: flags read back clear
    task automatic test_reset_state();
        offer_word(CMD_CHECK, 8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK, 8'(NUM_TIMERS - 1), 1'b1, 32'hFFFF_FFFF);
    endtask

    // one-shot fires once, check clears the flag
    task automatic test_one_shot();
        offer_word(CMD_INIT,  8'd0, 1'b0, 32'd1);
        offer_word(CMD_TICK,  8'd255, 1'b1, 32'hFFFF_FFFF);   // fields ignored
        offer_word(CMD_CHECK, 8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK, 8'd0, 1'b0, 32'd0);
    endtask

    // auto-reload fires every second tick
    task automatic test_auto_reload();
        offer_word(CMD_INIT,  8'(NUM_TIMERS - 1), 1'b1, 32'd2);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK, 8'(NUM_TIMERS - 1), 1'b0, 32'd0);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK, 8'(NUM_TIMERS - 1), 1'b0, 32'd0);
    endtask

    // auto-reload with reload zero: flag set once, then the timer idles
    task automatic test_zero_reload();
        offer_word(CMD_INIT,   8'd3, 1'b1, 32'd1);
        offer_word(CMD_CHANGE, 8'd3, 1'b1, 32'd0);
        offer_word(CMD_TICK,   8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK,  8'd3, 1'b0, 32'd0);
        offer_word(CMD_TICK,   8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK,  8'd3, 1'b0, 32'd0);
    endtask

    // first index past the bank and the top index: dropped, check gives 0
    task automatic test_out_of_range();
        offer_word(CMD_INIT,   8'(NUM_TIMERS), 1'b0, 32'd1);
        offer_word(CMD_CHANGE, 8'd255, 1'b1, 32'd1);
        offer_word(CMD_CHECK,  8'd255, 1'b1, 32'hFFFF_FFFF);
    endtask

    // re-init over a set flag keeps it; max period
    task automatic test_init_keeps_flag();
        offer_word(CMD_INIT,  8'd0, 1'b0, 32'd1);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_INIT,  8'd0, 1'b1, 32'hFFFF_FFFF);
        offer_word(CMD_CHECK, 8'd0, 1'b0, 32'd0);
    endtask

    // Result side holds off for a long stretch while checks keep coming:
    // the output register fills and the next check stalls the input.
    task automatic test_backpressure();
        drain_results();
        gap_max   = 0;
        burst_max = 8;
        stall_pct = 0;
        hold_req  = HOLD_OFF;
        offer_word(CMD_INIT,  8'd1, 1'b1, 32'd1);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK, 8'd1, 1'b0, 32'd0);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_INIT,  8'd2, 1'b0, 32'd1);
        offer_word(CMD_CHECK, 8'd1, 1'b0, 32'd0);
        offer_word(CMD_TICK,  8'd0, 1'b0, 32'd0);
        offer_word(CMD_CHECK, 8'd2, 1'b0, 32'd0);
        offer_word(CMD_CHECK, 8'd2, 1'b0, 32'd0);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly in-range indexes and short periods so timers
    // actually expire; some out-of-range, zero and full-width periods.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(int count, int gaps, int burst, int stall);
        t_cmd      cmd;
        bit [7:0]  idx;
        bit [31:0] per;
        int        pick;
        gap_max   = gaps;
        burst_max = burst;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      cmd = CMD_TICK;
            else if (pick < 55) cmd = CMD_INIT;
            else if (pick < 65) cmd = CMD_CHANGE;
            else                cmd = CMD_CHECK;
            if ($urandom_range(0, 99) < 88)
                idx = 8'($urandom_range(0, NUM_TIMERS - 1));
            else
                idx = 8'($urandom_range(NUM_TIMERS, 255));
            pick = $urandom_range(0, 99);
            if (pick < 10)      per = 32'd0;
            else if (pick < 75) per = $urandom_range(1, 6);
            else if (pick < 90) per = $urandom_range(7, 40);
            else                per = $urandom;
            offer_word(cmd, idx, 1'($urandom_range(0, 1)), per);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int errors;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_one_shot();
        test_auto_reload();
        test_zero_reload();
        test_out_of_range();
        test_init_keeps_flag();
        test_backpressure();

        test_random_traffic(250, 0, 1, 0);     // no idling on either side
        test_random_traffic(300, 3, 8, 20);
        test_random_traffic(250, 10, 4, 60);
        test_random_traffic(250, 1, 20, 5);
        test_random_traffic(170, 6, 6, 35);

        repeat (SWEEP_CYCLES) @(posedge i_clk);

        errors = mismatches + expected_flags.size();
        if (expected_flags.size() != 0)
            $display("%0d result words never arrived", expected_flags.size());
        $display("Covered %0d words: %0d ticks, %0d inits, %0d changes, %0d checks",
                 n_words[CMD_TICK] + n_words[CMD_INIT] + n_words[CMD_CHANGE]
                 + n_words[CMD_CHECK], n_words[CMD_TICK], n_words[CMD_INIT],
                 n_words[CMD_CHANGE], n_words[CMD_CHECK]);
        $display("%0d result words checked, %0d expirations seen, %0d mismatches",
                 n_results, n_flags_seen, mismatches);
        if (errors == 0)
            $display("PASS multi_channel_reload_timer_bank");
        else
            $display("FAIL multi_channel_reload_timer_bank");
        $finish;
    end

endmodule

FILE: multi_channel_reload_timer_bank.f
+incdir+hw/rtl
hw/rtl/mcrtb_pkg.sv
hw/rtl/mcrtb_ram.sv
hw/rtl/multi_channel_reload_timer_bank.sv
verif/tb_multi_channel_reload_timer_bank.sv
